// ===== rtl/core/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// AES package
// Shared types, codes and byte-, word- and block-level functions for the AES block cipher.
// ----------------------------------------------------------------------------
package aes_pkg;

   localparam logic [1:0] MODE_ECB_ENC = 2'd0;
   localparam logic [1:0] MODE_ECB_DEC = 2'd1;
   localparam logic [1:0] MODE_CBC_ENC = 2'd2;
   localparam logic [1:0] MODE_CBC_DEC = 2'd3;

   localparam logic [1:0] KEY_128 = 2'd0;
   localparam logic [1:0] KEY_192 = 2'd1;

   localparam logic [2:0] CSR_KEY_SIZE = 3'd0;
   localparam logic [2:0] CSR_MODE     = 3'd1;
   localparam logic [2:0] CSR_KEY0     = 3'd2;
   localparam logic [2:0] CSR_KEY1     = 3'd3;
   localparam logic [2:0] CSR_KEY2     = 3'd4;
   localparam logic [2:0] CSR_KEY3     = 3'd5;
   localparam logic [2:0] CSR_IV_HI    = 3'd6;
   localparam logic [2:0] CSR_IV_LO    = 3'd7;

   // item handed from the front queue to the cipher engine
   typedef struct packed {
      logic [127:0] block;
      logic         first;
   } queue_item_type;

   function automatic logic [7:0] sbox_fwd(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[a];
   endfunction

   function automatic logic [7:0] sbox_inv(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
      return t[a];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox_fwd(w[31:24]), sbox_fwd(w[23:16]), sbox_fwd(w[15:8]), sbox_fwd(w[7:0])};
   endfunction

   // one column of MixColumns, forward or inverse
   function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inv);
      logic [7:0] a [4];
      logic [7:0] a2 [4];
      logic [7:0] a4 [4];
      logic [7:0] a8 [4];
      logic [7:0] m2 [4];
      logic [7:0] m3 [4];
      logic [7:0] m9 [4];
      logic [7:0] mb [4];
      logic [7:0] md [4];
      logic [7:0] me [4];
      logic [31:0] r;
      for (int k = 0; k < 4; k++) begin
         a[k]  = c[31 - 8*k -: 8];
         a2[k] = xtime(a[k]);
         a4[k] = xtime(a2[k]);
         a8[k] = xtime(a4[k]);
         m2[k] = a2[k];
         m3[k] = a2[k] ^ a[k];
         m9[k] = a8[k] ^ a[k];
         mb[k] = a8[k] ^ a2[k] ^ a[k];
         md[k] = a8[k] ^ a4[k] ^ a[k];
         me[k] = a8[k] ^ a4[k] ^ a2[k];
      end
      for (int rr = 0; rr < 4; rr++) begin
         if (inv) begin
            r[31 - 8*rr -: 8] = me[rr] ^ mb[(rr+1)%4] ^ md[(rr+2)%4] ^ m9[(rr+3)%4];
         end else begin
            r[31 - 8*rr -: 8] = m2[rr] ^ m3[(rr+1)%4] ^ a[(rr+2)%4] ^ a[(rr+3)%4];
         end
      end
      return r;
   endfunction

   // SubBytes + ShiftRows (forward) or InvShiftRows + InvSubBytes
   function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
      logic [127:0] o;
      for (int rr = 0; rr < 4; rr++) begin
         for (int c = 0; c < 4; c++) begin
            if (inv) begin
               o[127 - 8*(rr + 4*((c+rr)%4)) -: 8] = sbox_inv(s[127 - 8*(rr + 4*c) -: 8]);
            end else begin
               o[127 - 8*(rr + 4*c) -: 8] = sbox_fwd(s[127 - 8*(rr + 4*((c+rr)%4)) -: 8]);
            end
         end
      end
      return o;
   endfunction

   function automatic logic [127:0] mix_all(input logic [127:0] s, input logic inv);
      logic [127:0] o;
      for (int c = 0; c < 4; c++) begin
         o[127 - 32*c -: 32] = mix_col(s[127 - 32*c -: 32], inv);
      end
      return o;
   endfunction

endpackage

// ===== rtl/core/aes_front.sv =====
// ----------------------------------------------------------------------------
// AES front queue
// Accepts items and holds them in a two-entry queue for the cipher engine.
// ----------------------------------------------------------------------------
module aes_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_stall,
   input  aes_pkg::queue_item_type in_item,
   output logic                    out_valid,
   input  logic                    out_take,
   output aes_pkg::queue_item_type out_item
);
   import aes_pkg::*;

   queue_item_type mem_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;
   logic           push, pop;

   assign in_stall  = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && out_take;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end
endmodule

// ===== rtl/core/aes_engine.sv =====
// ----------------------------------------------------------------------------
// AES cipher engine
// Expands the key on a first block, then runs one round per cycle with
// CBC chaining and a registered output.
// ----------------------------------------------------------------------------
module aes_engine #(
   parameter int ROUND_KEY_WORDS = 60
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   output logic                    q_take,
   input  aes_pkg::queue_item_type q_item,
   input  logic [1:0]              key_size,
   input  logic [1:0]              cipher_mode,
   input  logic [255:0]            key,
   input  logic [127:0]            iv,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [127:0]            rsp_block
);
   import aes_pkg::*;

   localparam int RKW     = $clog2(ROUND_KEY_WORDS + 4);
   localparam int RK_ROWS = (ROUND_KEY_WORDS + 3) / 4;
   localparam int RRW     = $clog2(RK_ROWS);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EXPND = 3'd1;
   localparam logic [2:0] ST_LOAD  = 3'd2;
   localparam logic [2:0] ST_ROUND = 3'd3;
   localparam logic [2:0] ST_FINAL = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [2:0]   state_ff, state_in;
   logic [127:0] rk_mem [RK_ROWS];
   logic [127:0] rk_rd_ff;
   logic [RKW-1:0] widx_ff, widx_in;
   logic [31:0]  win_ff [8];
   logic [7:0]   rcon_ff, rcon_in;
   logic [2:0]   kpos_ff, kpos_in;
   logic [3:0]   nk_ff, nk_in;
   logic [3:0]   round_ff, round_in;
   logic [3:0]   nr;
   logic [127:0] st_ff, st_in;
   logic [127:0] in_blk_ff;
   logic [127:0] chain_ff, chain_in;
   logic         inv_ff;
   logic [127:0] out_ff, out_in;
   logic         outv_ff, outv_in;
   logic [31:0]  new_word, tmp;
   logic [3:0]   rd_row;
   logic [RKW-1:0] total;
   logic         rk_we;
   logic [127:0] sbs, rnd;

   assign nr = nk_ff + 4'd6;
   assign total = RKW'(({3'b0, nk_ff} + 7'd7) << 2);

   // next expanded word: window holds w[i-nk] in slot 0 up to w[i-1] in slot nk-1
   always_comb begin
      tmp = win_ff[nk_ff[2:0] - 3'd1];
      if (kpos_ff == 3'd0) begin
         tmp = sub_word({tmp[23:0], tmp[31:24]}) ^ {rcon_ff, 24'h0};
      end else if (nk_ff == 4'd8 && kpos_ff == 3'd4) begin
         tmp = sub_word(tmp);
      end
      new_word = win_ff[0] ^ tmp;
   end

   // round key row for the next cycle; one row of four words per round
   always_comb begin
      if (state_ff == ST_IDLE) begin
         rd_row = cipher_mode[0] ? nr : 4'd0;
      end else if (state_ff == ST_LOAD) begin
         rd_row = inv_ff ? nr - 4'd1 : 4'd1;
      end else if (state_ff == ST_ROUND) begin
         rd_row = inv_ff ? round_ff - 4'd1 : round_ff + 4'd1;
      end else begin
         rd_row = inv_ff ? nr : 4'd0;
      end
   end

   // key store: one word written per cycle, one row read per cycle
   assign rk_we = (state_ff == ST_EXPND) && (widx_ff < total);
   always_ff @(posedge clock) begin
      if (rk_we && (32'(widx_ff) < ROUND_KEY_WORDS)) begin
         rk_mem[RRW'(widx_ff[RKW-1:2])][127 - 32*widx_ff[1:0] -: 32] <=
            (widx_ff < RKW'(nk_ff)) ? win_ff[widx_ff[2:0]] : new_word;
      end
      for (int c = 0; c < 4; c++) begin
         rk_rd_ff[127 - 32*c -: 32] <= (32'(rd_row) * 4 + c < ROUND_KEY_WORDS) ?
            rk_mem[RRW'(rd_row)][127 - 32*c -: 32] : 32'h0;
      end
   end

   // round datapath
   always_comb begin
      sbs = sub_shift(st_ff, inv_ff);
      if (inv_ff) begin
         rnd = mix_all(sbs ^ rk_rd_ff, 1'b1);
      end else begin
         rnd = mix_all(sbs, 1'b0) ^ rk_rd_ff;
      end
   end

   assign q_take = (state_ff == ST_IDLE) && q_valid;

   // sequencer
   always_comb begin
      state_in = state_ff;
      widx_in  = widx_ff;
      rcon_in  = rcon_ff;
      kpos_in  = kpos_ff;
      nk_in    = nk_ff;
      round_in = round_ff;
      st_in    = st_ff;
      chain_in = chain_ff;
      out_in   = out_ff;
      outv_in  = outv_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               if (q_item.first) begin
                  nk_in    = (key_size == KEY_128) ? 4'd4 : ((key_size == KEY_192) ? 4'd6 : 4'd8);
                  widx_in  = '0;
                  rcon_in  = 8'h01;
                  kpos_in  = 3'd0;
                  chain_in = iv;
                  state_in = ST_EXPND;
               end else begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_EXPND: begin
            if (widx_ff == total) begin
               state_in = ST_LOAD;
            end else begin
               widx_in = widx_ff + 1'b1;
               if (widx_ff >= RKW'(nk_ff)) begin
                  if (kpos_ff == 3'd0) rcon_in = xtime(rcon_ff);
                  kpos_in = (kpos_ff == nk_ff[2:0] - 3'd1) ? 3'd0 : kpos_ff + 3'd1;
               end
            end
         end
         ST_LOAD: begin
            st_in    = ((cipher_mode == MODE_CBC_ENC) ? in_blk_ff ^ chain_ff : in_blk_ff)
                       ^ rk_rd_ff;
            round_in = inv_ff ? nr - 4'd1 : 4'd1;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            st_in = rnd;
            if (inv_ff ? (round_ff == 4'd1) : (round_ff == nr - 4'd1)) begin
               state_in = ST_FINAL;
            end else begin
               round_in = inv_ff ? round_ff - 4'd1 : round_ff + 4'd1;
            end
         end
         ST_FINAL: begin
            st_in    = sbs ^ rk_rd_ff;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!outv_ff || !rsp_stall) begin
               outv_in = 1'b1;
               unique case (cipher_mode)
                  MODE_CBC_ENC: begin
                     out_in   = st_ff;
                     chain_in = st_ff;
                  end
                  MODE_CBC_DEC: begin
                     out_in   = st_ff ^ chain_ff;
                     chain_in = in_blk_ff;
                  end
                  default: out_in = st_ff;
               endcase
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         outv_ff  <= 1'b0;
         chain_ff <= '0;
         nk_ff    <= 4'd4;
      end else begin
         state_ff <= state_in;
         outv_ff  <= outv_in;
         chain_ff <= chain_in;
         nk_ff    <= nk_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      widx_ff  <= widx_in;
      rcon_ff  <= rcon_in;
      kpos_ff  <= kpos_in;
      round_ff <= round_in;
      st_ff    <= st_in;
      out_ff   <= out_in;
      if (q_take) begin
         in_blk_ff <= q_item.block;
         inv_ff    <= cipher_mode[0];
      end
      // key window: load key, then slide one word per generated word
      if (state_ff == ST_IDLE) begin
         for (int i = 0; i < 8; i++) win_ff[i] <= key[255 - 32*i -: 32];
      end else if (state_ff == ST_EXPND && widx_ff >= RKW'(nk_ff) && widx_ff < total) begin
         for (int i = 0; i < 8; i++) begin
            if (3'(i) == nk_ff[2:0] - 3'd1) begin
               win_ff[i] <= new_word;
            end else begin
               win_ff[i] <= win_ff[(i + 1) % 8];
            end
         end
      end
   end

   assign rsp_valid = outv_ff;
   assign rsp_block = out_ff;
endmodule

// ===== rtl/core/aes_block_cipher_ecb_cbc.sv =====
// ----------------------------------------------------------------------------
// AES block cipher, ECB and CBC
// AES-128/192/256 on one 128-bit item at a time, behind a two-entry queue.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  req       in   req_valid/stall    req_block_hi, req_block_lo, req_first_block
//  rsp       out  rsp_valid/stall    rsp_result_hi, rsp_result_lo
//  csr       in   csr_write_enable   csr_index, csr_write_data
//
// The round engine takes one item at a time and runs one round per
// cycle; a first block adds a key expansion before its rounds.
// The queue accepts items while the engine runs; the output register holds
// a result under rsp_stall. Reset is synchronous and clears control state.
// ----------------------------------------------------------------------------
module aes_block_cipher_ecb_cbc #(
   parameter int ROUND_KEY_WORDS = 60
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_block_hi,
   input  logic [63:0] req_block_lo,
   input  logic        req_first_block,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_result_hi,
   output logic [63:0] rsp_result_lo,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_write_data
);
   import aes_pkg::*;

   logic [1:0]     key_size_ff, cipher_mode_ff;
   logic [255:0]   key_ff;
   logic [127:0]   iv_ff;
   queue_item_type in_item, q_item;
   logic           q_valid, q_take;
   logic [127:0]   rsp_block;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_size_ff    <= '0;
         cipher_mode_ff <= '0;
         key_ff         <= '0;
         iv_ff          <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_KEY_SIZE: key_size_ff    <= csr_write_data[1:0];
            CSR_MODE:     cipher_mode_ff <= csr_write_data[1:0];
            CSR_KEY0:     key_ff[255:192] <= csr_write_data;
            CSR_KEY1:     key_ff[191:128] <= csr_write_data;
            CSR_KEY2:     key_ff[127:64]  <= csr_write_data;
            CSR_KEY3:     key_ff[63:0]    <= csr_write_data;
            CSR_IV_HI:    iv_ff[127:64]   <= csr_write_data;
            CSR_IV_LO:    iv_ff[63:0]     <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign in_item = '{block: {req_block_hi, req_block_lo}, first: req_first_block};

   aes_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_item   (in_item),
      .out_valid (q_valid),
      .out_take  (q_take),
      .out_item  (q_item)
   );

   aes_engine #(.ROUND_KEY_WORDS(ROUND_KEY_WORDS)) u_engine (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_take      (q_take),
      .q_item      (q_item),
      .key_size    (key_size_ff),
      .cipher_mode (cipher_mode_ff),
      .key         (key_ff),
      .iv          (iv_ff),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_block   (rsp_block)
   );

   assign rsp_result_hi = rsp_block[127:64];
   assign rsp_result_lo = rsp_block[63:0];

   // a queued item is taken only while the queue has one
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      q_take |-> q_valid) else $error("engine took from empty queue");

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_block))
      else $error("result changed under stall");

   // the queue stalls requests only while it holds an item
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> q_valid) else $error("stall with empty queue");
endmodule

// ===== dv/aes_block_cipher_ecb_cbc_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES ECB/CBC scoreboard
// Watches the register port and both item channels, keeps its own AES state
// (configuration, round keys, chaining value) and checks every result item
// against the oldest predicted block.
// ----------------------------------------------------------------------------
module aes_block_cipher_ecb_cbc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [63:0] req_block_hi,
   input  logic [63:0] req_block_lo,
   input  logic        req_first_block,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [63:0] rsp_result_hi,
   input  logic [63:0] rsp_result_lo,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_write_data,
   output int          fail_count,
   output int          pending_count,
   output int          blocks_checked,
   output int          messages_started
);
   import aes_pkg::*;

   typedef struct {
      logic [63:0] hi;
      logic [63:0] lo;
   } cipher_block_type;

   cipher_block_type expected_blocks[$];

   // shadow configuration and cipher state
   logic [1:0]  key_size_q;
   logic [1:0]  mode_q;
   logic [63:0] key_q [4];
   logic [63:0] iv_q [2];
   logic [31:0] round_keys [60];
   logic [63:0] chain_q [2];
   logic [7:0]  fwd_tab [256];
   logic [7:0]  inv_tab [256];

   function automatic logic [7:0] xt(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] r;
      r = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[0]) r ^= a;
         a = xt(a);
         b = b >> 1;
      end
      return r;
   endfunction

   // S-box from the field inverse and the affine map
   initial begin
      logic [7:0] inv_v;
      logic [7:0] s;
      for (int x = 0; x < 256; x++) begin
         inv_v = 8'h01;
         if (x == 0) inv_v = 8'h00;
         else for (int k = 0; k < 254; k++) inv_v = gf_mul(inv_v, 8'(x));
         s = inv_v ^ {inv_v[6:0], inv_v[7]} ^ {inv_v[5:0], inv_v[7:6]}
             ^ {inv_v[4:0], inv_v[7:5]} ^ {inv_v[3:0], inv_v[7:4]} ^ 8'h63;
         fwd_tab[x] = s;
         inv_tab[s] = 8'(x);
      end
   end

   function automatic int key_words_n();
      return key_size_q == KEY_128 ? 4 : (key_size_q == KEY_192 ? 6 : 8);
   endfunction

   function automatic logic [31:0] sub_w(input logic [31:0] w);
      return {fwd_tab[w[31:24]], fwd_tab[w[23:16]], fwd_tab[w[15:8]], fwd_tab[w[7:0]]};
   endfunction

   task automatic expand_keys();
      int nk;
      int total;
      logic [7:0] rcon;
      logic [31:0] t;
      nk = key_words_n();
      total = 4 * (nk + 7);
      rcon = 8'h01;
      for (int i = 0; i < nk; i++)
         round_keys[i] = i[0] ? key_q[i >> 1][31:0] : key_q[i >> 1][63:32];
      for (int i = nk; i < total; i++) begin
         t = round_keys[i - 1];
         if (i % nk == 0) begin
            t = sub_w({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
            rcon = xt(rcon);
         end else if (nk > 6 && i % nk == 4) begin
            t = sub_w(t);
         end
         round_keys[i] = round_keys[i - nk] ^ t;
      end
   endtask

   function automatic logic [127:0] aes_block(input logic [127:0] blk, input logic decrypt);
      logic [7:0] st [16];
      logic [7:0] tmp [16];
      logic [7:0] mcol [4];
      logic [7:0] a [4];
      logic [31:0] k;
      logic [127:0] o;
      int nr;
      int rnd;
      nr = key_words_n() + 6;
      if (decrypt) begin
         mcol[0] = 8'h0e;
         mcol[1] = 8'h0b;
         mcol[2] = 8'h0d;
         mcol[3] = 8'h09;
      end else begin
         mcol[0] = 8'h02;
         mcol[1] = 8'h03;
         mcol[2] = 8'h01;
         mcol[3] = 8'h01;
      end
      for (int i = 0; i < 16; i++) st[i] = blk[127 - 8*i -: 8];
      for (int step = 0; step <= nr; step++) begin
         rnd = decrypt ? nr - step : step;
         if (step > 0) begin
            // byte substitution with row shift
            tmp = st;
            for (int r = 0; r < 4; r++)
               for (int c = 0; c < 4; c++)
                  if (decrypt) st[r + 4*((c + r) % 4)] = inv_tab[tmp[r + 4*c]];
                  else st[r + 4*c] = fwd_tab[tmp[r + 4*((c + r) % 4)]];
         end
         // forward mixes before the key, inverse after it
         for (int pass = 0; pass < 2; pass++) begin
            if (pass == (decrypt ? 0 : 1)) begin
               for (int c = 0; c < 4; c++) begin
                  k = round_keys[rnd*4 + c];
                  st[4*c] ^= k[31:24];
                  st[4*c+1] ^= k[23:16];
                  st[4*c+2] ^= k[15:8];
                  st[4*c+3] ^= k[7:0];
               end
            end else if (step > 0 && step < nr) begin
               for (int c = 0; c < 4; c++) begin
                  for (int j = 0; j < 4; j++) a[j] = st[4*c + j];
                  for (int r = 0; r < 4; r++) begin
                     st[4*c + r] = 8'h00;
                     for (int j = 0; j < 4; j++)
                        st[4*c + r] ^= gf_mul(a[j], mcol[(j - r + 4) % 4]);
                  end
               end
            end
         end
      end
      for (int i = 0; i < 16; i++) o[127 - 8*i -: 8] = st[i];
      return o;
   endfunction

   // predict one result item from an accepted input item
   task automatic predict_block(input logic [63:0] hi, input logic [63:0] lo,
                                input logic first);
      logic [127:0] r;
      cipher_block_type e;
      if (first) begin
         expand_keys();
         chain_q[0] = iv_q[0];
         chain_q[1] = iv_q[1];
         messages_started++;
      end
      case (mode_q)
         MODE_ECB_ENC: r = aes_block({hi, lo}, 1'b0);
         MODE_ECB_DEC: r = aes_block({hi, lo}, 1'b1);
         MODE_CBC_ENC: begin
            r = aes_block({hi ^ chain_q[0], lo ^ chain_q[1]}, 1'b0);
            chain_q[0] = r[127:64];
            chain_q[1] = r[63:0];
         end
         default: begin
            r = aes_block({hi, lo}, 1'b1) ^ {chain_q[0], chain_q[1]};
            chain_q[0] = hi;
            chain_q[1] = lo;
         end
      endcase
      e.hi = r[127:64];
      e.lo = r[63:0];
      expected_blocks.push_back(e);
   endtask

   always @(posedge clock) begin
      cipher_block_type e;
      if (reset) begin
         key_size_q = KEY_128;
         mode_q = MODE_ECB_ENC;
         for (int i = 0; i < 4; i++) key_q[i] = '0;
         iv_q[0] = '0;
         iv_q[1] = '0;
         chain_q[0] = '0;
         chain_q[1] = '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_KEY_SIZE: key_size_q = csr_write_data[1:0];
               CSR_MODE:     mode_q = csr_write_data[1:0];
               CSR_KEY0:     key_q[0] = csr_write_data;
               CSR_KEY1:     key_q[1] = csr_write_data;
               CSR_KEY2:     key_q[2] = csr_write_data;
               CSR_KEY3:     key_q[3] = csr_write_data;
               CSR_IV_HI:    iv_q[0] = csr_write_data;
               default:      iv_q[1] = csr_write_data;
            endcase
         end
         if (req_valid && !req_stall)
            predict_block(req_block_hi, req_block_lo, req_first_block);
         if (rsp_valid && !rsp_stall) begin
            if (expected_blocks.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected result item %h_%h", $realtime,
                           rsp_result_hi, rsp_result_lo);
            end else begin
               e = expected_blocks.pop_front();
               blocks_checked++;
               if (e.hi !== rsp_result_hi || e.lo !== rsp_result_lo) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: result mismatch: expected hi %h lo %h, got hi %h lo %h",
                              $realtime, e.hi, e.lo, rsp_result_hi, rsp_result_lo);
               end
            end
         end
      end
      pending_count = expected_blocks.size();
   end

   initial begin
      fail_count = 0;
      pending_count = 0;
      blocks_checked = 0;
      messages_started = 0;
   end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES ECB/CBC block test
// Directed blocks over all modes and key sizes with extreme keys and data,
// then random messages with random stalls on both channels; results are
// checked by the scoreboard module.
// ----------------------------------------------------------------------------
module testbench;
   import aes_pkg::*;

   localparam logic [1:0] KEY_SIZE_256 = 2'd2;
   localparam int         CYCLE_LIMIT  = 1000000;
   localparam int         ITEM_TARGET  = 950;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [63:0] req_block_hi;
   logic [63:0] req_block_lo;
   logic        req_first_block;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_result_hi;
   logic [63:0] rsp_result_lo;
   logic        csr_write_enable;
   logic [2:0]  csr_index;
   logic [63:0] csr_write_data;

   int  fail_count;
   int  pending_count;
   int  blocks_checked;
   int  messages_started;
   int  items_sent;
   int  cycle_count;
   bit  calm;

   aes_block_cipher_ecb_cbc dut (.*);

   aes_block_cipher_ecb_cbc_checker scoreboard (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver stalls
   always @(posedge clock)
      rsp_stall <= reset ? 1'b0 : (!calm && $urandom_range(99) < 33);

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("aes_block_cipher_ecb_cbc test failed");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] pick_word();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return rand64();
      endcase
   endfunction

   // one register write per edge; caller drops the enable after a batch
   task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
   endtask

   task automatic write_key(input logic [1:0] ks, input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3);
      write_reg(CSR_KEY_SIZE, {62'h0, ks});
      write_reg(CSR_KEY0, k0);
      write_reg(CSR_KEY1, k1);
      write_reg(CSR_KEY2, k2);
      write_reg(CSR_KEY3, k3);
   endtask

   task automatic send_block(input logic [63:0] hi, input logic [63:0] lo, input logic first);
      while (!calm && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_block_hi <= hi;
      req_block_lo <= lo;
      req_first_block <= first;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // hold the sender until every result is back, then let the engine settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   initial begin
      logic [1:0] ks;
      logic       fresh;
      int         len;
      reset = 1'b1;
      req_valid = 1'b0;
      req_block_hi = '0;
      req_block_lo = '0;
      req_first_block = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = CSR_KEY_SIZE;
      csr_write_data = '0;
      items_sent = 0;
      cycle_count = 0;
      calm = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: each mode at each key size, zero and all-ones keys and data
      for (int m = 0; m < 4; m++) begin
         for (int s = 0; s < 3; s++) begin
            ks = 2'(s);
            if (s == 1) write_key(ks, '1, '1, '1, '1);
            else write_key(ks, '0, '0, '0, '0);
            write_reg(CSR_MODE, 64'(m));
            write_reg(CSR_IV_HI, (m == MODE_CBC_DEC) ? '1 : 64'h0);
            write_reg(CSR_IV_LO, rand64());
            csr_write_enable <= 1'b0;
            @(posedge clock);
            send_block('0, '0, 1'b1);
            send_block('1, '1, (s == 2 && m == MODE_CBC_ENC));
            drain();
         end
      end
      // key changed mid-message applies only from the next first block
      write_key(KEY_SIZE_256, rand64(), rand64(), rand64(), rand64());
      csr_write_enable <= 1'b0;
      @(posedge clock);
      send_block(rand64(), rand64(), 1'b0);
      send_block(rand64(), rand64(), 1'b1);
      drain();

      // random messages
      while (items_sent < ITEM_TARGET) begin
         fresh = ($urandom_range(3) != 0);
         if (fresh) begin
            ks = 2'($urandom_range(2));
            write_key(ks, pick_word(), pick_word(), pick_word(), pick_word());
         end else if ($urandom_range(1)) begin
            write_reg(CSR_KEY0, pick_word());
            write_reg(CSR_KEY3, pick_word());
         end
         write_reg(CSR_MODE, 64'($urandom_range(3)));
         write_reg(CSR_IV_HI, pick_word());
         write_reg(CSR_IV_LO, pick_word());
         csr_write_enable <= 1'b0;
         @(posedge clock);
         len = $urandom_range(30, 1);
         for (int i = 0; i < len; i++) begin
            calm = (items_sent >= 400 && items_sent < 550);
            send_block(pick_word(), pick_word(),
                       (i == 0) ? fresh : ($urandom_range(11) == 0));
         end
         drain();
      end
      calm = 1'b0;

      $display("Checked %0d result blocks over %0d messages, all modes and key sizes.",
               blocks_checked, messages_started);
      $display("Random stalls on both channels, %0d blocks sent.", items_sent);
      if (fail_count == 0 && pending_count == 0) begin
         $display("aes_block_cipher_ecb_cbc test passed");
      end else begin
         $display("aes_block_cipher_ecb_cbc test failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/aes_pkg.sv
rtl/core/aes_front.sv
rtl/core/aes_engine.sv
rtl/core/aes_block_cipher_ecb_cbc.sv
dv/aes_block_cipher_ecb_cbc_checker.sv
dv/testbench.sv
